// File: rtl/s256cr_pkg.sv
// Package with the SHA-256 round constants, initial hash value and round functions.
package s256cr_pkg;

  localparam int unsigned WordWidth  = 32;
  localparam int unsigned NumWords   = 8;
  localparam int unsigned NumRounds  = 64;
  localparam int unsigned RoundWidth = 6;

  typedef logic [WordWidth-1:0]  word_t;
  typedef logic [RoundWidth-1:0] round_t;
  typedef word_t [NumWords-1:0]  state_t;

  localparam round_t FirstRound = round_t'(0);
  localparam round_t LastRound  = round_t'(NumRounds - 1);

  // Standard initial hash value, word 0 first
  localparam word_t InitHash [NumWords] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  // Round constant table
  localparam word_t RoundConst [NumRounds] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a317, 32'hc67178f2
  };

  function automatic word_t rotr(input word_t x, input int unsigned n);
    rotr = (x >> n) | (x << (WordWidth - n));
  endfunction

  function automatic word_t big_sigma_a(input word_t x);
    big_sigma_a = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic word_t big_sigma_e(input word_t x);
    big_sigma_e = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic word_t choose_bits(input word_t x, input word_t y, input word_t z);
    choose_bits = (x & y) ^ (~x & z);
  endfunction

  function automatic word_t majority_bits(input word_t x, input word_t y, input word_t z);
    majority_bits = (x & y) ^ (x & z) ^ (y & z);
  endfunction

  function automatic state_t init_state();
    state_t s;
    for (int i = 0; i < NumWords; i++) begin
      s[i] = InitHash[i];
    end
    init_state = s;
  endfunction

endpackage

// File: rtl/sha256_compression_rounds.sv
// SHA-256 compression: one round per schedule word, digest after every 64th word.
// A word is taken into the input register and runs its round from there; after the last
// word of a block the working variables are added into the hash and the digest is registered.
// Throughput: one schedule word per cycle, except while a block's last word waits for the
// previous digest to be taken; a single round datapath lies between the input register and the working variables.
// Reset: hash state to the initial value, working variables and round count to zero.
module sha256_compression_rounds
  import s256cr_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  // Input schedule words
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [31:0]  s_axis_tdata,   // [31:0] schedule_word
  input  logic         s_axis_tuser,   // [0] start_message
  // Digest output
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [255:0] m_axis_tdata    // [31:0] digest_word0 ... [255:224] digest_word7
);

  logic   in_valid_q;
  word_t  word_q;
  logic   start_q;
  round_t round_q, round_d;
  state_t hash_q, hash_d;
  state_t vars_q, vars_d;
  logic   out_valid_q;
  state_t digest_q;

  logic   out_free;
  logic   last_round;
  logic   proc;
  logic   s_fire;
  state_t hash_src;
  state_t vars_src;
  word_t  sum_e;
  word_t  sum_a;

  // Process the held word unless it closes a block while the digest is still waiting
  assign out_free      = !out_valid_q || m_axis_tready;
  assign last_round    = (round_q == LastRound);
  assign proc          = in_valid_q && (!last_round || out_free);
  assign s_axis_tready = !in_valid_q || proc;
  assign s_fire        = s_axis_tvalid && s_axis_tready;

  // Capture the incoming transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      word_q  <= s_axis_tdata;
      start_q <= s_axis_tuser;
    end
  end

  // Round datapath: load on the first round, then one compression round
  always_comb begin
    hash_src = hash_q;
    vars_src = vars_q;
    if (round_q == FirstRound) begin
      if (start_q) begin
        hash_src = init_state();
      end
      vars_src = hash_src;
    end

    sum_e = vars_src[7] + big_sigma_e(vars_src[4])
          + choose_bits(vars_src[4], vars_src[5], vars_src[6])
          + RoundConst[round_q] + word_q;
    sum_a = big_sigma_a(vars_src[0])
          + majority_bits(vars_src[0], vars_src[1], vars_src[2]);

    vars_d[7] = vars_src[6];
    vars_d[6] = vars_src[5];
    vars_d[5] = vars_src[4];
    vars_d[4] = vars_src[3] + sum_e;
    vars_d[3] = vars_src[2];
    vars_d[2] = vars_src[1];
    vars_d[1] = vars_src[0];
    vars_d[0] = sum_e + sum_a;

    hash_d = hash_src;
    if (last_round) begin
      for (int i = 0; i < NumWords; i++) begin
        hash_d[i] = hash_src[i] + vars_d[i];
      end
    end

    round_d = round_q + round_t'(1);
  end

  // Advance working state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      round_q <= FirstRound;
      hash_q  <= init_state();
      vars_q  <= '0;
    end else if (proc) begin
      round_q <= round_d;
      hash_q  <= hash_d;
      vars_q  <= vars_d;
    end
  end

  // Hold the digest until the transaction is taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (proc && last_round) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc && last_round) begin
      digest_q <= hash_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = digest_q;

  // A new digest appears only after a closing round
  a_digest_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(proc && last_round))
    else $error("digest raised without a closing round");

  // A closing round never overwrites a digest that is still waiting
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (proc && last_round) |-> (!out_valid_q || m_axis_tready))
    else $error("digest overwritten while stalled");

  // Every processed word advances the round count by one
  a_round_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    proc |=> (round_q == round_t'($past(round_q) + round_t'(1))))
    else $error("round count did not advance");

endmodule
